[rtl/unicode_stream_transcoder_macros.svh]
// Assertion macros for the transcoder.
`ifndef UNICODE_STREAM_TRANSCODER_MACROS_SVH
`define UNICODE_STREAM_TRANSCODER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define UST_ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("transcoder property violated");
// Check that a condition in one cycle implies another in the next cycle.
`define UST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("transcoder sequence violated");
`else
`define UST_ASSERT_PROP(lbl, clk, rstn, prop)
`define UST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/ust_pkg.sv]
`default_nettype none

package ust_pkg;

    typedef enum logic [1:0] {
        ENC_ASCII = 2'd0,
        ENC_UTF8  = 2'd1,
        ENC_UTF16 = 2'd2,
        ENC_UTF32 = 2'd3
    } t_enc;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_UNIT       = 4'd1,
        ERR_LEAD       = 4'd2,
        ERR_CONT       = 4'd3,
        ERR_TRUNC      = 4'd4,
        ERR_OVERLONG   = 4'd5,
        ERR_SURROGATE  = 4'd6,
        ERR_RANGE      = 4'd7,
        ERR_UNREPR     = 4'd8
    } t_err;

    typedef enum logic [1:0] {
        CFG_SOURCE = 2'd0,
        CFG_TARGET = 2'd1
    } t_cfg_idx;

    localparam int UST_QDEPTH = 2;
    localparam int UST_QPTR_W = (UST_QDEPTH > 1) ? $clog2(UST_QDEPTH) : 1;
    localparam int UST_QCNT_W = $clog2(UST_QDEPTH + 1);

    // One decoded beat handed from the front to the back.
    typedef struct packed {
        logic        has_unit;
        logic [20:0] scalar;
        t_err        err;
        logic [31:0] epos;
        logic        eot;
    } t_cmd;

    typedef struct packed {
        logic [20:0] out_unit;
        logic        unit_valid;
        logic        last_of_run;
        logic        text_done;
        t_err        error_code;
        logic [31:0] error_position;
    } t_result;

endpackage

`default_nettype wire

[rtl/ust_front.sv]
`default_nettype none

module ust_front
    import ust_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_clear,
    input  wire logic        i_accept,
    input  wire logic [31:0] i_code_unit,
    input  wire logic        i_end_of_text,
    input  wire t_enc        i_src_enc,
    input  wire t_enc        i_tgt_enc,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd
);

    logic [20:0] r_partial,    n_partial;
    logic [1:0]  r_needed,     n_needed;
    logic [2:0]  r_seq_len,    n_seq_len;
    logic [31:0] r_lead_pos,   n_lead_pos;
    logic [31:0] r_unit_pos,   n_unit_pos;
    logic [31:0] r_scalar_pos, n_scalar_pos;
    logic        r_err_latched, n_err_latched;

    logic [31:0] u;
    logic [7:0]  u8;
    logic [20:0] sc;
    logic        have;
    t_err        err;
    logic [31:0] epos;

    assign u  = i_code_unit;
    assign u8 = u[7:0];

    always_comb begin
        n_partial     = r_partial;
        n_needed      = r_needed;
        n_seq_len     = r_seq_len;
        n_lead_pos    = r_lead_pos;
        n_unit_pos    = (r_unit_pos == '1) ? r_unit_pos : r_unit_pos + 32'd1;
        n_scalar_pos  = r_scalar_pos;
        n_err_latched = r_err_latched;
        sc            = '0;
        have          = 1'b0;
        err           = ERR_NONE;
        epos          = '0;

        if (!r_err_latched) begin
            case (i_src_enc)
                ENC_ASCII: begin
                    if (u > 32'h7F) begin
                        err  = ERR_UNIT;
                        epos = r_unit_pos;
                    end else begin
                        sc   = {14'd0, u[6:0]};
                        have = 1'b1;
                    end
                end
                ENC_UTF8: begin
                    if (r_needed == 2'd0) begin
                        n_lead_pos = r_unit_pos;
                        if (u[31:8] != 24'd0) begin
                            err  = ERR_UNIT;
                            epos = r_unit_pos;
                        end else if (u8 <= 8'h7F) begin
                            sc   = {14'd0, u8[6:0]};
                            have = 1'b1;
                        end else if (u8 >= 8'hC2 && u8 <= 8'hDF) begin
                            n_partial = {16'd0, u8[4:0]};
                            n_seq_len = 3'd2;
                            n_needed  = 2'd1;
                        end else if (u8 >= 8'hE0 && u8 <= 8'hEF) begin
                            n_partial = {17'd0, u8[3:0]};
                            n_seq_len = 3'd3;
                            n_needed  = 2'd2;
                        end else if (u8 >= 8'hF0 && u8 <= 8'hF4) begin
                            n_partial = {18'd0, u8[2:0]};
                            n_seq_len = 3'd4;
                            n_needed  = 2'd3;
                        end else begin
                            err  = ERR_LEAD;
                            epos = r_unit_pos;
                        end
                    end else if (u[31:8] != 24'd0 || u8[7:6] != 2'b10) begin
                        err  = ERR_CONT;
                        epos = r_unit_pos;
                    end else begin
                        n_partial = {r_partial[14:0], u8[5:0]};
                        n_needed  = r_needed - 2'd1;
                        if (n_needed == 2'd0) begin
                            if ((r_seq_len == 3'd2 && n_partial < 21'h80) ||
                                (r_seq_len == 3'd3 && n_partial < 21'h800) ||
                                (r_seq_len == 3'd4 && n_partial < 21'h10000)) begin
                                err = ERR_OVERLONG;
                            end else if (n_partial >= 21'hD800 && n_partial <= 21'hDFFF) begin
                                err = ERR_SURROGATE;
                            end else if (n_partial > 21'h10FFFF) begin
                                err = ERR_RANGE;
                            end else begin
                                sc   = n_partial;
                                have = 1'b1;
                            end
                            if (err != ERR_NONE) begin
                                epos = r_lead_pos;
                            end
                        end
                    end
                end
                ENC_UTF16: begin
                    if (r_needed == 2'd0) begin
                        if (u[31:16] != 16'd0) begin
                            err  = ERR_UNIT;
                            epos = r_unit_pos;
                        end else if (u[15:10] == 6'b110110) begin
                            n_partial  = {11'd0, u[9:0]};
                            n_needed   = 2'd1;
                            n_lead_pos = r_unit_pos;
                        end else if (u[15:10] == 6'b110111) begin
                            err  = ERR_SURROGATE;
                            epos = r_unit_pos;
                        end else begin
                            sc   = {5'd0, u[15:0]};
                            have = 1'b1;
                        end
                    end else if (u[31:10] != 22'b110111) begin
                        err  = ERR_SURROGATE;
                        epos = r_unit_pos;
                    end else begin
                        // high bits plus one plane offset, low ten bits straight
                        sc       = {r_partial[9:0] + 10'd0 + 11'd64, u[9:0]};
                        n_needed = 2'd0;
                        have     = 1'b1;
                    end
                end
                default: begin
                    if (u >= 32'hD800 && u <= 32'hDFFF) begin
                        err  = ERR_SURROGATE;
                        epos = r_unit_pos;
                    end else if (u > 32'h10FFFF) begin
                        err  = ERR_RANGE;
                        epos = r_unit_pos;
                    end else begin
                        sc   = u[20:0];
                        have = 1'b1;
                    end
                end
            endcase

            if (have) begin
                if (i_tgt_enc == ENC_ASCII && sc > 21'h7F) begin
                    err  = ERR_UNREPR;
                    epos = r_scalar_pos;
                end
                n_scalar_pos = (r_scalar_pos == '1) ? r_scalar_pos : r_scalar_pos + 32'd1;
            end
            if (err == ERR_NONE && i_end_of_text && n_needed != 2'd0) begin
                err  = ERR_TRUNC;
                epos = n_lead_pos;
            end
            if (err != ERR_NONE) begin
                n_err_latched = 1'b1;
            end
        end

        // end of text returns the stream to its starting point
        if (i_end_of_text) begin
            n_partial     = '0;
            n_needed      = '0;
            n_seq_len     = '0;
            n_lead_pos    = '0;
            n_unit_pos    = '0;
            n_scalar_pos  = '0;
            n_err_latched = 1'b0;
        end
    end

    always_comb begin
        o_cmd.has_unit = have && (err == ERR_NONE);
        o_cmd.scalar   = sc;
        o_cmd.err      = err;
        o_cmd.epos     = epos;
        o_cmd.eot      = i_end_of_text;
        o_cmd_valid    = i_accept && (o_cmd.has_unit || err != ERR_NONE || i_end_of_text);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_partial     <= '0;
            r_needed      <= '0;
            r_seq_len     <= '0;
            r_lead_pos    <= '0;
            r_unit_pos    <= '0;
            r_scalar_pos  <= '0;
            r_err_latched <= 1'b0;
        end else if (i_accept) begin
            r_partial     <= n_partial;
            r_needed      <= n_needed;
            r_seq_len     <= n_seq_len;
            r_lead_pos    <= n_lead_pos;
            r_unit_pos    <= n_unit_pos;
            r_scalar_pos  <= n_scalar_pos;
            r_err_latched <= n_err_latched;
        end
    end

endmodule

`default_nettype wire

[rtl/ust_cmd_fifo.sv]
`default_nettype none

module ust_cmd_fifo
    import ust_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd                  r_mem [UST_QDEPTH];
    logic [UST_QPTR_W-1:0] r_wptr;
    logic [UST_QPTR_W-1:0] r_rptr;
    logic [UST_QCNT_W-1:0] r_count;

    localparam logic [UST_QPTR_W-1:0] PtrLast = UST_QPTR_W'(UST_QDEPTH - 1);
    localparam logic [UST_QCNT_W-1:0] CntFull = UST_QCNT_W'(UST_QDEPTH);

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PtrLast) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrLast) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/ust_back.sv]
`default_nettype none

module ust_back
    import ust_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_enc i_tgt_enc,
    input  wire logic i_cmd_avail,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_out_pop,
    output logic      o_out_avail,
    output t_result   o_out
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_result    r_out;

    logic [2:0]  cnt;
    logic [20:0] s;
    logic [19:0] t;
    logic [20:0] unit;
    logic        last_unit;
    logic        load;
    t_result     n_out;

    assign s = i_cmd.scalar;
    assign t = s[19:0] - 20'h10000;

    // unit count of the scalar in the target encoding
    always_comb begin
        case (i_tgt_enc)
            ENC_UTF8: begin
                if (s <= 21'h7F)        cnt = 3'd1;
                else if (s <= 21'h7FF)  cnt = 3'd2;
                else if (s <= 21'hFFFF) cnt = 3'd3;
                else                    cnt = 3'd4;
            end
            ENC_UTF16: cnt = (s > 21'hFFFF) ? 3'd2 : 3'd1;
            default:   cnt = 3'd1;
        endcase
    end

    always_comb begin
        unit = s;
        case (i_tgt_enc)
            ENC_UTF8: begin
                case (cnt)
                    3'd2: begin
                        case (r_idx)
                            2'd0:    unit = {13'd0, 3'b110, s[10:6]};
                            default: unit = {13'd0, 2'b10, s[5:0]};
                        endcase
                    end
                    3'd3: begin
                        case (r_idx)
                            2'd0:    unit = {13'd0, 4'b1110, s[15:12]};
                            2'd1:    unit = {13'd0, 2'b10, s[11:6]};
                            default: unit = {13'd0, 2'b10, s[5:0]};
                        endcase
                    end
                    3'd4: begin
                        case (r_idx)
                            2'd0:    unit = {13'd0, 5'b11110, s[20:18]};
                            2'd1:    unit = {13'd0, 2'b10, s[17:12]};
                            2'd2:    unit = {13'd0, 2'b10, s[11:6]};
                            default: unit = {13'd0, 2'b10, s[5:0]};
                        endcase
                    end
                    default: unit = s;
                endcase
            end
            ENC_UTF16: begin
                if (cnt == 3'd2) begin
                    case (r_idx)
                        2'd0:    unit = {5'd0, 6'b110110, t[19:10]};
                        default: unit = {5'd0, 6'b110111, t[9:0]};
                    endcase
                end
            end
            default: unit = s;
        endcase
    end

    assign last_unit = !i_cmd.has_unit || ({1'b0, r_idx} == cnt - 3'd1);
    assign load      = i_cmd_avail && (!r_out_valid || i_out_pop);
    assign o_cmd_pop = load && last_unit;

    always_comb begin
        n_out.out_unit       = i_cmd.has_unit ? unit : '0;
        n_out.unit_valid     = i_cmd.has_unit;
        n_out.last_of_run    = last_unit;
        n_out.text_done      = last_unit && i_cmd.eot;
        n_out.error_code     = i_cmd.err;
        n_out.error_position = i_cmd.epos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= last_unit ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_avail = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

[rtl/unicode_stream_transcoder.sv]
// Path: accepted items are decoded, queued, then loaded into the output register.
// Throughput: one item per cycle while each yields one result beat and every beat is popped;
// an item whose scalar encodes to k target units yields k beats, stepped by the back end's
// unit index, and a two-entry queue between decoder and encoder absorbs the difference.
// Reset: synchronous, active low; both encodings return to UTF-8 and stream state,
// queue and output valid flag clear. A source or target configuration write restarts the text.
`default_nettype none
`include "unicode_stream_transcoder_macros.svh"

module unicode_stream_transcoder
    import ust_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_code_unit,
    input  wire logic        i_end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      o_out_unit,
    output logic             o_unit_valid,
    output logic             o_last_of_run,
    output logic             o_text_done,
    output logic [3:0]       o_error_code,
    output logic [31:0]      o_error_position
);

    t_enc    r_src_enc;
    t_enc    r_tgt_enc;
    logic    cfg_clear;
    logic    in_accept;
    logic    q_push;
    t_cmd    q_in;
    logic    q_full;
    logic    q_empty;
    t_cmd    q_head;
    logic    q_pop;
    logic    out_avail;
    logic    out_pop;
    t_result out_beat;

    assign cfg_clear = i_cfg_we &&
        (i_cfg_index == CFG_SOURCE || i_cfg_index == CFG_TARGET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_enc <= ENC_UTF8;
            r_tgt_enc <= ENC_UTF8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE: r_src_enc <= t_enc'(i_cfg_data);
                CFG_TARGET: r_tgt_enc <= t_enc'(i_cfg_data);
                default:    ;
            endcase
        end
    end

    assign full      = q_full;
    assign in_accept = push && !q_full;

    ust_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (cfg_clear),
        .i_accept      (in_accept),
        .i_code_unit   (i_code_unit),
        .i_end_of_text (i_end_of_text),
        .i_src_enc     (r_src_enc),
        .i_tgt_enc     (r_tgt_enc),
        .o_cmd_valid   (q_push),
        .o_cmd         (q_in)
    );

    ust_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    assign out_pop = pop && out_avail;

    ust_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tgt_enc   (r_tgt_enc),
        .i_cmd_avail (!q_empty),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_pop),
        .i_out_pop   (out_pop),
        .o_out_avail (out_avail),
        .o_out       (out_beat)
    );

    assign empty            = !out_avail;
    assign o_out_unit       = out_beat.out_unit;
    assign o_unit_valid     = out_beat.unit_valid;
    assign o_last_of_run    = out_beat.last_of_run;
    assign o_text_done      = out_beat.text_done;
    assign o_error_code     = out_beat.error_code;
    assign o_error_position = out_beat.error_position;

    `UST_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, q_push, !q_empty)
    `UST_ASSERT_PROP(a_push_room, i_clk, i_rst_n, !q_push || !q_full)
    `UST_ASSERT_PROP(a_done_is_last, i_clk, i_rst_n, empty || !o_text_done || o_last_of_run)
    `UST_ASSERT_PROP(a_unit_no_err, i_clk, i_rst_n, empty || !o_unit_valid || o_error_code == ERR_NONE)
    `UST_ASSERT_PROP(a_err_no_unit, i_clk, i_rst_n, empty || o_unit_valid || o_out_unit == 21'd0)

endmodule

`default_nettype wire

[dv/unicode_stream_transcoder_tb.sv]
module unicode_stream_transcoder_tb;
    import ust_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int UNITS_PER_PAIR = 19;
    localparam int HOLD_OFF = 4;
    localparam int DIRECTED_COUNT = 22;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    localparam logic [31:0] SCALAR_EXTREMES [10] = '{
        32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800,
        32'hD7FF, 32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF
    };

    // bit 32 is the end-of-text flag; reset configuration is utf8 to utf8
    localparam logic [32:0] DIRECTED_UNITS [DIRECTED_COUNT] = '{
        {1'b0, 32'h00},
        {1'b0, 32'hF4}, {1'b0, 32'h8F}, {1'b0, 32'hBF}, {1'b0, 32'hBF},
        {1'b1, 32'h100},
        {1'b1, 32'hC0},
        {1'b0, 32'hE0}, {1'b0, 32'h80}, {1'b1, 32'h80},
        {1'b0, 32'hED}, {1'b0, 32'hA0}, {1'b1, 32'h80},
        {1'b0, 32'hF4}, {1'b0, 32'h90}, {1'b0, 32'h80}, {1'b1, 32'h80},
        {1'b0, 32'hC2}, {1'b0, 32'h41}, {1'b1, 32'h42},
        {1'b0, 32'hE2}, {1'b1, 32'h82}
    };

    class transcode_scoreboard;
        t_enc        src_enc;
        t_enc        dst_enc;
        logic [20:0] partial;
        logic [1:0]  need;
        logic [2:0]  seq_len;
        logic [31:0] lead_pos;
        logic [31:0] unit_pos;
        logic [31:0] scalar_pos;
        bit          latched;
        t_result     expected_q[$];
        int unsigned mismatches;
        int unsigned beats_checked;
        int unsigned error_beats;
        int unsigned texts_closed;

        function new();
            src_enc = ENC_UTF8;
            dst_enc = ENC_UTF8;
            clear_text();
        endfunction

        function void clear_text();
            partial = '0;
            need = '0;
            seq_len = '0;
            lead_pos = '0;
            unit_pos = '0;
            scalar_pos = '0;
            latched = 1'b0;
        endfunction

        function void configure(logic [1:0] idx, logic [1:0] val);
            case (idx)
                CFG_SOURCE: begin
                    src_enc = t_enc'(val);
                    clear_text();
                end
                CFG_TARGET: begin
                    dst_enc = t_enc'(val);
                    clear_text();
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        function t_result make_beat(logic [20:0] unit, logic valid, t_err err,
                                    logic [31:0] pos);
            t_result r;
            r.out_unit = unit;
            r.unit_valid = valid;
            r.last_of_run = 1'b0;
            r.text_done = 1'b0;
            r.error_code = err;
            r.error_position = pos;
            return r;
        endfunction

        function int encode_target(logic [31:0] s, output logic [20:0] units [4]);
            logic [31:0] t;
            units = '{default: '0};
            if (dst_enc == ENC_UTF8) begin
                if (s <= 32'h7F) begin
                    units[0] = s[20:0];
                    return 1;
                end
                if (s <= 32'h7FF) begin
                    units[0] = 21'(32'hC0 | (s >> 6));
                    units[1] = 21'(32'h80 | (s & 32'h3F));
                    return 2;
                end
                if (s <= 32'hFFFF) begin
                    units[0] = 21'(32'hE0 | (s >> 12));
                    units[1] = 21'(32'h80 | ((s >> 6) & 32'h3F));
                    units[2] = 21'(32'h80 | (s & 32'h3F));
                    return 3;
                end
                units[0] = 21'(32'hF0 | (s >> 18));
                units[1] = 21'(32'h80 | ((s >> 12) & 32'h3F));
                units[2] = 21'(32'h80 | ((s >> 6) & 32'h3F));
                units[3] = 21'(32'h80 | (s & 32'h3F));
                return 4;
            end
            if (dst_enc == ENC_UTF16 && s > 32'hFFFF) begin
                t = s - 32'h10000;
                units[0] = 21'(32'hD800 | (t >> 10));
                units[1] = 21'(32'hDC00 | (t & 32'h3FF));
                return 2;
            end
            units[0] = s[20:0];
            return 1;
        endfunction

        // Returns 0 when the beat is swallowed by a latched error.
        function bit note_input(logic [31:0] u, bit eot);
            t_result     step_q[$];
            t_result     r;
            t_err        err;
            logic [31:0] epos;
            logic [31:0] sc;
            logic [31:0] pos;
            logic [20:0] units [4];
            int          cnt;
            bit          have;
            bit          live;

            live = !(latched && !eot);
            err = ERR_NONE;
            epos = '0;
            sc = '0;
            have = 1'b0;
            pos = unit_pos;

            if (!latched) begin
                case (src_enc)
                    ENC_ASCII: begin
                        if (u > 32'h7F) begin
                            err = ERR_UNIT;
                            epos = pos;
                        end else begin
                            sc = u;
                            have = 1'b1;
                        end
                    end
                    ENC_UTF8: begin
                        if (need == 2'd0) begin
                            lead_pos = pos;
                            if (u > 32'hFF) begin
                                err = ERR_UNIT;
                                epos = pos;
                            end else if (u <= 32'h7F) begin
                                sc = u;
                                have = 1'b1;
                            end else if (u >= 32'hC2 && u <= 32'hDF) begin
                                partial = 21'(u & 32'h1F);
                                seq_len = 3'd2;
                                need = 2'd1;
                            end else if (u >= 32'hE0 && u <= 32'hEF) begin
                                partial = 21'(u & 32'h0F);
                                seq_len = 3'd3;
                                need = 2'd2;
                            end else if (u >= 32'hF0 && u <= 32'hF4) begin
                                partial = 21'(u & 32'h07);
                                seq_len = 3'd4;
                                need = 2'd3;
                            end else begin
                                err = ERR_LEAD;
                                epos = pos;
                            end
                        end else if (u > 32'hFF || (u & 32'hC0) != 32'h80) begin
                            err = ERR_CONT;
                            epos = pos;
                        end else begin
                            partial = {partial[14:0], u[5:0]};
                            need = need - 2'd1;
                            if (need == 2'd0) begin
                                sc = 32'(partial);
                                if ((seq_len == 3'd2 && sc < 32'h80) ||
                                    (seq_len == 3'd3 && sc < 32'h800) ||
                                    (seq_len == 3'd4 && sc < 32'h10000))
                                    err = ERR_OVERLONG;
                                else if (sc >= 32'hD800 && sc <= 32'hDFFF)
                                    err = ERR_SURROGATE;
                                else if (sc > 32'h10FFFF)
                                    err = ERR_RANGE;
                                else
                                    have = 1'b1;
                                if (err != ERR_NONE) epos = lead_pos;
                            end
                        end
                    end
                    ENC_UTF16: begin
                        if (need == 2'd0) begin
                            if (u > 32'hFFFF) begin
                                err = ERR_UNIT;
                                epos = pos;
                            end else if (u >= 32'hD800 && u <= 32'hDBFF) begin
                                partial = 21'(u - 32'hD800);
                                need = 2'd1;
                                lead_pos = pos;
                            end else if (u >= 32'hDC00 && u <= 32'hDFFF) begin
                                err = ERR_SURROGATE;
                                epos = pos;
                            end else begin
                                sc = u;
                                have = 1'b1;
                            end
                        end else if (u < 32'hDC00 || u > 32'hDFFF) begin
                            err = ERR_SURROGATE;
                            epos = pos;
                        end else begin
                            sc = 32'h10000 + ((32'(partial) << 10) | (u - 32'hDC00));
                            need = 2'd0;
                            have = 1'b1;
                        end
                    end
                    default: begin
                        if (u >= 32'hD800 && u <= 32'hDFFF) begin
                            err = ERR_SURROGATE;
                            epos = pos;
                        end else if (u > 32'h10FFFF) begin
                            err = ERR_RANGE;
                            epos = pos;
                        end else begin
                            sc = u;
                            have = 1'b1;
                        end
                    end
                endcase

                if (have) begin
                    if (dst_enc == ENC_ASCII && sc > 32'h7F) begin
                        err = ERR_UNREPR;
                        epos = scalar_pos;
                    end else begin
                        cnt = encode_target(sc, units);
                        for (int k = 0; k < cnt; k++)
                            step_q = {step_q, make_beat(units[k], 1'b1, ERR_NONE, '0)};
                    end
                    scalar_pos = bump(scalar_pos);
                end
                if (err == ERR_NONE && eot && need != 2'd0) begin
                    err = ERR_TRUNC;
                    epos = lead_pos;
                end
                if (err != ERR_NONE) begin
                    step_q = {step_q, make_beat('0, 1'b0, err, epos)};
                    latched = 1'b1;
                end
            end

            if (eot && step_q.size() == 0)
                step_q = {step_q, make_beat('0, 1'b0, ERR_NONE, '0)};
            if (step_q.size() > 0) begin
                r = step_q[step_q.size() - 1];
                r.last_of_run = 1'b1;
                r.text_done = eot;
                step_q[step_q.size() - 1] = r;
            end

            unit_pos = bump(unit_pos);
            if (eot) clear_text();
            foreach (step_q[k]) expected_q = {expected_q, step_q[k]};
            return live;
        endfunction

        function string beat_text(t_result b);
            return $sformatf("unit=%h valid=%b last=%b done=%b err=%0d pos=%0d",
                             b.out_unit, b.unit_valid, b.last_of_run, b.text_done,
                             b.error_code, b.error_position);
        endfunction

        function void report(string what, t_result want, t_result got);
            if (mismatches < REPORT_LIMIT)
                $display("%s at beat %0d: expected %s, got %s",
                         what, beats_checked, beat_text(want), beat_text(got));
            mismatches++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            bit      bad;
            if (expected_q.size() == 0) begin
                report("unexpected beat", '0, got);
            end else begin
                want = expected_q.pop_front();
                bad = 1'b0;
                if (got.out_unit !== want.out_unit) bad = 1'b1;
                if (got.unit_valid !== want.unit_valid) bad = 1'b1;
                if (got.last_of_run !== want.last_of_run) bad = 1'b1;
                if (got.text_done !== want.text_done) bad = 1'b1;
                if (got.error_code !== want.error_code) bad = 1'b1;
                if (got.error_position !== want.error_position) bad = 1'b1;
                if (bad) report("mismatch", want, got);
                if (want.error_code != ERR_NONE) error_beats++;
                if (want.text_done) texts_closed++;
            end
            beats_checked++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [1:0]  i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_code_unit = '0;
    logic        i_end_of_text = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [20:0] o_out_unit;
    logic        o_unit_valid;
    logic        o_last_of_run;
    logic        o_text_done;
    logic [3:0]  o_error_code;
    logic [31:0] o_error_position;

    transcode_scoreboard sb = new();
    t_enc        cur_src = ENC_UTF8;
    t_enc        cur_dst = ENC_UTF8;
    logic [31:0] text_units[$];
    int          burst_left = 0;
    int unsigned live_items = 0;
    int          idle_cycles = 0;

    unicode_stream_transcoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_code_unit      (i_code_unit),
        .i_end_of_text    (i_end_of_text),
        .empty            (empty),
        .pop              (pop),
        .o_out_unit       (o_out_unit),
        .o_unit_valid     (o_unit_valid),
        .o_last_of_run    (o_last_of_run),
        .o_text_done      (o_text_done),
        .o_error_code     (o_error_code),
        .o_error_position (o_error_position)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort if neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: check accepted beats and cycle through stall patterns.
    initial begin
        t_result got;
        int      cyc;
        int      hold;
        cyc = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.out_unit = o_out_unit;
                got.unit_valid = o_unit_valid;
                got.last_of_run = o_last_of_run;
                got.text_done = o_text_done;
                got.error_code = t_err'(o_error_code);
                got.error_position = o_error_position;
                sb.check_result(got);
            end
            cyc++;
            case ((cyc / 80) % 4)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= (cyc % 4 == 0);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        pop <= 1'b0;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 5) == 0) hold = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    task automatic send_unit(logic [31:0] unit, bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_code_unit <= unit;
        i_end_of_text <= last;
        do @(posedge i_clk); while (full !== 1'b0);
        if (sb.note_input(unit, last)) live_items++;
    endtask

    // Hold the sender until every expected beat has drained.
    task automatic drain(int extra);
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.configure(idx, val);
        if (idx == CFG_SOURCE) cur_src = t_enc'(val);
        if (idx == CFG_TARGET) cur_dst = t_enc'(val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int utf8_len(logic [31:0] s);
        if (s <= 32'h7F) return 1;
        if (s <= 32'h7FF) return 2;
        if (s <= 32'hFFFF) return 3;
        return 4;
    endfunction

    function automatic void add_unit(logic [31:0] v);
        text_units = {text_units, v};
    endfunction

    // Encode s in len bytes whether or not that length is legal.
    function automatic void queue_utf8(logic [31:0] s, int len);
        case (len)
            1: add_unit(s);
            2: begin
                add_unit(32'hC0 | s[10:6]);
                add_unit(32'h80 | s[5:0]);
            end
            3: begin
                add_unit(32'hE0 | s[15:12]);
                add_unit(32'h80 | s[11:6]);
                add_unit(32'h80 | s[5:0]);
            end
            default: begin
                add_unit(32'hF0 | s[20:18]);
                add_unit(32'h80 | s[17:12]);
                add_unit(32'h80 | s[11:6]);
                add_unit(32'h80 | s[5:0]);
            end
        endcase
    endfunction

    function automatic void queue_valid(logic [31:0] s);
        logic [31:0] t;
        case (cur_src)
            ENC_UTF8: queue_utf8(s, utf8_len(s));
            ENC_UTF16: begin
                if (s > 32'hFFFF) begin
                    t = s - 32'h10000;
                    add_unit(32'hD800 | t[19:10]);
                    add_unit(32'hDC00 | t[9:0]);
                end else begin
                    add_unit(s);
                end
            end
            default: add_unit(s);
        endcase
    endfunction

    function automatic void queue_broken(logic [31:0] s);
        int          len;
        int          mark;
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: add_unit($urandom);
            1: add_unit($urandom_range(0, 32'hFF));
            2: add_unit($urandom_range(0, 32'hFFFF));
            3: add_unit($urandom_range(32'hD800, 32'hDFFF));
            4: add_unit($urandom_range(32'h110000, 32'h1FFFFF));
            5: begin
                // drop the tail of a multi-unit sequence
                mark = text_units.size();
                queue_valid(s);
                if (text_units.size() - mark > 1) void'(text_units.pop_back());
            end
            6: begin
                len = $urandom_range(2, 4);
                v = $urandom_range(0, (len == 2) ? 32'h7F : (len == 3) ? 32'h7FF : 32'hFFFF);
                queue_utf8(v, len);
            end
            7: queue_utf8($urandom_range(32'hD800, 32'hDFFF), 3);
            8: queue_utf8($urandom_range(32'h110000, 32'h1FFFFF), 4);
            default: begin
                if (cur_src == ENC_UTF16) begin
                    add_unit($urandom_range(32'hD800, 32'hDBFF));
                    add_unit($urandom_range(0, 32'hFFFF));
                end else begin
                    // replace the last continuation with a bad one
                    v = $urandom_range(32'h80, 32'h10FFFF);
                    queue_utf8(v, utf8_len(v));
                    void'(text_units.pop_back());
                    case ($urandom_range(0, 2))
                        0: add_unit($urandom_range(0, 32'h7F));
                        1: add_unit($urandom_range(32'hC0, 32'hFF));
                        default: add_unit($urandom);
                    endcase
                end
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_scalar();
        logic [31:0] v;
        if ((cur_src == ENC_ASCII || cur_dst == ENC_ASCII) && $urandom_range(0, 3) != 0)
            return $urandom_range(0, 32'h7F);
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h7F);
            5, 6, 7: return $urandom_range(32'h80, 32'h7FF);
            8, 9, 10: begin
                v = $urandom_range(32'h800, 32'hFFFF);
                if (v >= 32'hD800 && v <= 32'hDFFF) v ^= 32'h800;
                return v;
            end
            11, 12, 13: return $urandom_range(32'h10000, 32'h10FFFF);
            default: return SCALAR_EXTREMES[$urandom_range(0, 9)];
        endcase
    endfunction

    task automatic send_queued();
        for (int k = 0; k < text_units.size(); k++)
            send_unit(text_units[k], k == text_units.size() - 1);
        text_units.delete();
    endtask

    task automatic send_text();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                queue_broken(pick_scalar());
            else
                queue_valid(pick_scalar());
        end
        send_queued();
    endtask

    initial begin
        logic [3:0]  pair;
        int unsigned phase_start;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Run on the reset configuration first.
        for (int k = 0; k < DIRECTED_COUNT; k++)
            send_unit(DIRECTED_UNITS[k][31:0], DIRECTED_UNITS[k][32]);

        for (int ph = 0; ph < 16; ph++) begin
            pair = 4'(ph * 7);
            drain(HOLD_OFF);
            write_cfg(CFG_SOURCE, pair[3:2]);
            write_cfg(CFG_TARGET, pair[1:0]);
            if (ph == 7) write_cfg(CFG_UNUSED_IDX, 2'($urandom_range(0, 3)));
            phase_start = live_items;
            while (live_items - phase_start < UNITS_PER_PAIR) begin
                send_text();
                if (ph == 9 && live_items - phase_start >= UNITS_PER_PAIR / 2 &&
                    live_items - phase_start < UNITS_PER_PAIR / 2 + 6)
                    drain(0);
            end
        end

        drain(2 * HOLD_OFF);

        $display("Checked %0d result beats from %0d live units over all encoding pairs.",
                 sb.beats_checked, live_items);
        $display("Error beats: %0d, texts closed: %0d, mismatches: %0d.",
                 sb.error_beats, sb.texts_closed, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ust_pkg.sv
rtl/ust_front.sv
rtl/ust_cmd_fifo.sv
rtl/ust_back.sv
rtl/unicode_stream_transcoder.sv
dv/unicode_stream_transcoder_tb.sv
